// ----- design/transitive_closure_engine_assert.svh -----
// ----------------------------------------------------------------------------
// Transitive closure engine assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef TRANSITIVE_CLOSURE_ENGINE_ASSERT_SVH
`define TRANSITIVE_CLOSURE_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define TCE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tce assertion failed");

`define TCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tce assertion failed");

`else

`define TCE_ASSERT_IMPL(lbl, ante, cons)

`define TCE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- design/tce_pkg.sv -----
// ----------------------------------------------------------------------------
// Transitive closure engine package
// Shared widths, state encoding, memory request type and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tce_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int VTX_W            = 6;
  localparam int ROW_W            = 64;
  localparam int CNT_W            = 7;
  localparam logic [CNT_W-1:0] VC_RESET = 7'd64;

  localparam logic REQ_EDGE    = 1'b0;
  localparam logic REQ_CLOSURE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_WR,
    ST_K_RD,
    ST_K_LD,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_HOLD
  } tce_state_t;

  typedef struct packed {
    logic             rd_en;
    logic [VTX_W-1:0] rd_addr;
    logic             wr_en;
    logic [VTX_W-1:0] wr_addr;
    logic [ROW_W-1:0] wr_data;
  } mem_req_t;

  function automatic logic [ROW_W-1:0] col_mask(input logic [VTX_W-1:0] last);
    logic [ROW_W-1:0] m;
    for (int j = 0; j < ROW_W; j++) begin
      m[j] = (VTX_W'(j) <= last);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- design/transitive_closure_engine.sv -----
// An edge write reads the source row and, if both vertices are in range,
// writes it back with the dst bit updated; a closure makes a row pass per pivot
// vertex, then emits each row, held while out_stall is high. One transaction
// at a time; the row memory has a single read and a single write port.
// Reset: rst is synchronous; it clears the matrix to all zeros through row valid
// bits and sets vertex_count to 64.
// ----------------------------------------------------------------------------
// Transitive closure engine
// Stores a boolean adjacency matrix, applies edge updates and runs Warshall's
// closure over the vertices in use, emitting one row per vertex in use for each closure.
// ----------------------------------------------------------------------------
`default_nettype none

module transitive_closure_engine
  import tce_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             req_type,
  input  wire logic [VTX_W-1:0] src_vertex,
  input  wire logic [VTX_W-1:0] dst_vertex,
  input  wire logic             edge_bit,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [VTX_W-1:0] row_index,
  output logic      [ROW_W-1:0] row_bits,
  output logic                  last_row
);

  logic [CNT_W-1:0] vertex_count;
  mem_req_t         mreq;
  logic [ROW_W-1:0] rd_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VC_RESET;
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  tce_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .vertex_count(vertex_count),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .src_vertex  (src_vertex),
    .dst_vertex  (dst_vertex),
    .edge_bit    (edge_bit),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .row_index   (row_index),
    .row_bits    (row_bits),
    .last_row    (last_row),
    .mreq        (mreq),
    .rd_row      (rd_row)
  );

  tce_row_mem #(
    .DEPTH(MAX_VERTICES)
  ) u_row_mem (
    .clk   (clk),
    .rst   (rst),
    .mreq  (mreq),
    .rd_row(rd_row)
  );

endmodule

`default_nettype wire

// ----- design/tce_row_mem.sv -----
// ----------------------------------------------------------------------------
// Transitive closure engine row memory
// Adjacency rows in a one-read, one-write synchronous memory; per-row valid
// bits make unwritten rows read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_row_mem
  import tce_pkg::*;
#(
  parameter int DEPTH = MAX_VERTICES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mem_req_t         mreq,
  output logic      [ROW_W-1:0] rd_row
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ROW_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] row_valid;
  logic [ROW_W-1:0] rdata;
  logic             rvalid;

  always_ff @(posedge clk) begin
    if (mreq.wr_en) begin
      mem[mreq.wr_addr[ADDR_W-1:0]] <= mreq.wr_data;
    end
    if (mreq.rd_en) begin
      rdata <= mem[mreq.rd_addr[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rvalid    <= 1'b0;
    end else begin
      if (mreq.wr_en) begin
        row_valid[mreq.wr_addr[ADDR_W-1:0]] <= 1'b1;
      end
      if (mreq.rd_en) begin
        rvalid <= row_valid[mreq.rd_addr[ADDR_W-1:0]];
      end
    end
  end

  assign rd_row = rvalid ? rdata : '0;

endmodule

`default_nettype wire

// ----- design/tce_ctrl.sv -----
// ----------------------------------------------------------------------------
// Transitive closure engine controller
// Sequences edge updates, the Warshall row passes and row emission over the
// row memory.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_ctrl
  import tce_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [CNT_W-1:0] vertex_count,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             req_type,
  input  wire logic [VTX_W-1:0] src_vertex,
  input  wire logic [VTX_W-1:0] dst_vertex,
  input  wire logic             edge_bit,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [VTX_W-1:0] row_index,
  output logic      [ROW_W-1:0] row_bits,
  output logic                  last_row,
  output mem_req_t              mreq,
  input  wire logic [ROW_W-1:0] rd_row
);

  `include "transitive_closure_engine_assert.svh"

  localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam logic [ADDR_W-1:0] LAST_MAX = ADDR_W'(MAX_VERTICES - 1);
  localparam logic [CNT_W-1:0]  VC_MAX   = CNT_W'(MAX_VERTICES);

  tce_state_t state, state_next;

  logic [ADDR_W-1:0] k, k_next;
  logic [ADDR_W-1:0] i, i_next;
  logic [ADDR_W-1:0] n_last, n_last_next;
  logic [ROW_W-1:0]  cols, cols_next;
  logic [ROW_W-1:0]  via, via_next;
  logic              wb_valid, wb_valid_next;
  logic [ADDR_W-1:0] wb_addr, wb_addr_next;
  logic [ADDR_W-1:0] ed_src, ed_src_next;
  logic [VTX_W-1:0]  ed_dst, ed_dst_next;
  logic              ed_bit, ed_bit_next;
  logic              ed_ok, ed_ok_next;
  logic [VTX_W-1:0]  row_index_next;
  logic [ROW_W-1:0]  row_bits_next;
  logic              last_row_next;
  logic [ADDR_W-1:0] vc_last;
  logic [ROW_W-1:0]  dst_onehot;
  logic              accept;

  always_comb begin
    if (vertex_count == '0) begin
      vc_last = '0;
    end else if (vertex_count > VC_MAX) begin
      vc_last = LAST_MAX;
    end else begin
      vc_last = ADDR_W'(vertex_count - CNT_W'(1));
    end
  end

  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_valid  = (state == ST_EMIT_HOLD);
  assign dst_onehot = ROW_W'(1) << ed_dst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      wb_valid <= 1'b0;
    end else begin
      state    <= state_next;
      wb_valid <= wb_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    k         <= k_next;
    i         <= i_next;
    n_last    <= n_last_next;
    cols      <= cols_next;
    via       <= via_next;
    wb_addr   <= wb_addr_next;
    ed_src    <= ed_src_next;
    ed_dst    <= ed_dst_next;
    ed_bit    <= ed_bit_next;
    ed_ok     <= ed_ok_next;
    row_index <= row_index_next;
    row_bits  <= row_bits_next;
    last_row  <= last_row_next;
  end

  always_comb begin
    state_next     = state;
    k_next         = k;
    i_next         = i;
    n_last_next    = n_last;
    cols_next      = cols;
    via_next       = via;
    wb_valid_next  = 1'b0;
    wb_addr_next   = wb_addr;
    ed_src_next    = ed_src;
    ed_dst_next    = ed_dst;
    ed_bit_next    = ed_bit;
    ed_ok_next     = ed_ok;
    row_index_next = row_index;
    row_bits_next  = row_bits;
    last_row_next  = last_row;
    mreq           = '0;

    // write back the row read in the previous scan cycle
    if (wb_valid) begin
      mreq.wr_en   = 1'b1;
      mreq.wr_addr = VTX_W'(wb_addr);
      mreq.wr_data = rd_row[VTX_W'(k)] ? (rd_row | via) : rd_row;
    end

    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req_type == REQ_EDGE) begin
            mreq.rd_en   = 1'b1;
            mreq.rd_addr = src_vertex;
            ed_src_next  = src_vertex[ADDR_W-1:0];
            ed_dst_next  = dst_vertex;
            ed_bit_next  = edge_bit;
            ed_ok_next   = ({1'b0, src_vertex} < VC_MAX) && ({1'b0, dst_vertex} < VC_MAX);
            state_next   = ST_EDGE_WR;
          end else begin
            n_last_next = vc_last;
            cols_next   = col_mask(VTX_W'(vc_last));
            k_next      = '0;
            state_next  = ST_K_RD;
          end
        end
      end
      ST_EDGE_WR: begin
        mreq.wr_en   = ed_ok;
        mreq.wr_addr = VTX_W'(ed_src);
        mreq.wr_data = ed_bit ? (rd_row | dst_onehot) : (rd_row & ~dst_onehot);
        state_next   = ST_IDLE;
      end
      ST_K_RD: begin
        mreq.rd_en   = 1'b1;
        mreq.rd_addr = VTX_W'(k);
        state_next   = ST_K_LD;
      end
      ST_K_LD: begin
        via_next   = rd_row & cols;
        i_next     = '0;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        mreq.rd_en    = 1'b1;
        mreq.rd_addr  = VTX_W'(i);
        wb_valid_next = 1'b1;
        wb_addr_next  = i;
        if (i == n_last) begin
          state_next = ST_DRAIN;
        end else begin
          i_next = i + ADDR_W'(1);
        end
      end
      ST_DRAIN: begin
        if (k == n_last) begin
          i_next     = '0;
          state_next = ST_EMIT_RD;
        end else begin
          k_next     = k + ADDR_W'(1);
          state_next = ST_K_RD;
        end
      end
      ST_EMIT_RD: begin
        mreq.rd_en   = 1'b1;
        mreq.rd_addr = VTX_W'(i);
        state_next   = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        row_index_next = VTX_W'(i);
        row_bits_next  = rd_row & cols;
        last_row_next  = (i == n_last);
        state_next     = ST_EMIT_HOLD;
      end
      ST_EMIT_HOLD: begin
        if (!out_stall) begin
          if (last_row) begin
            state_next = ST_IDLE;
          end else begin
            i_next     = i + ADDR_W'(1);
            state_next = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `TCE_ASSERT_IMPL(a_no_same_row_rw, mreq.rd_en && mreq.wr_en, mreq.rd_addr != mreq.wr_addr)
  `TCE_ASSERT_IMPL(a_busy_while_emit, out_valid, in_stall)
  `TCE_ASSERT_IMPL(a_row_in_range, out_valid, row_index <= VTX_W'(n_last))
  `TCE_ASSERT_NEXT(a_last_to_idle, out_valid && !out_stall && last_row, !in_stall)

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// Transitive closure engine testbench
// Drives edge writes and closure transactions over several vertex counts,
// predicts rows with a local Warshall matrix or a typed plan row and compares each
// accepted row field by field. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import tce_pkg::*;

  localparam int MAX_V          = 64;
  localparam int RANDOM_ITEMS   = 115;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLDOFF_CYCLES = 600;
  localparam int LIMIT_CYCLES   = 10000000;
  localparam int NUM_DIRECTED   = 23;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic [ROW_W-1:0] bits;
    logic             last_flag;
  } row_t;

  typedef struct packed {
    logic             is_cfg;
    logic [CNT_W-1:0] cfg_val;
    logic             req;
    logic [VTX_W-1:0] src;
    logic [VTX_W-1:0] dst;
    logic             eb;
    logic             typed;
    logic [ROW_W-1:0] typed_bits;
  } plan_step_t;

  logic             clk;
  logic             rst        = 1'b1;
  logic             cfg_we     = 1'b0;
  logic [CNT_W-1:0] cfg_wdata  = '0;
  logic             in_valid   = 1'b0;
  logic             in_stall;
  logic             req_type   = REQ_EDGE;
  logic [VTX_W-1:0] src_vertex = '0;
  logic [VTX_W-1:0] dst_vertex = '0;
  logic             edge_bit   = 1'b0;
  logic             out_valid;
  logic             out_stall  = 1'b0;
  logic [VTX_W-1:0] row_index;
  logic [ROW_W-1:0] row_bits;
  logic             last_row;

  logic             long_hold_req = 1'b0;

  logic [ROW_W-1:0] reach_rows [MAX_V];
  logic [CNT_W-1:0] vertex_count_cfg;
  row_t             expected_rows [$];
  row_t             closure_rows [$];
  plan_step_t       plan [NUM_DIRECTED];

  int mismatches    = 0;
  int rows_checked  = 0;
  int requests_sent = 0;
  int closures_sent = 0;
  int settings_used = 0;
  int cycles        = 0;

  transitive_closure_engine DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .src_vertex (src_vertex),
    .dst_vertex (dst_vertex),
    .edge_bit   (edge_bit),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .row_index  (row_index),
    .row_bits   (row_bits),
    .last_row   (last_row)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int active_vertices(input logic [CNT_W-1:0] cnt);
    if (cnt == 0) return 1;
    if (cnt > MAX_V) return MAX_V;
    return int'(cnt);
  endfunction

  task automatic apply_to_matrix(input logic req, input logic [VTX_W-1:0] src,
                                 input logic [VTX_W-1:0] dst, input logic eb);
    int n;
    logic [ROW_W-1:0] cols;
    logic [ROW_W-1:0] via;
    closure_rows.delete();
    if (req == REQ_EDGE) begin
      reach_rows[src][dst] = eb;
      return;
    end
    n = active_vertices(vertex_count_cfg);
    cols = (n == ROW_W) ? '1 : ((ROW_W'(1) << n) - ROW_W'(1));
    for (int k = 0; k < n; k++) begin
      via = reach_rows[k] & cols;
      for (int i = 0; i < n; i++) begin
        if (reach_rows[i][k]) reach_rows[i] = reach_rows[i] | via;
      end
    end
    for (int i = 0; i < n; i++) begin
      closure_rows.push_back('{vertex: VTX_W'(i), bits: reach_rows[i] & cols,
                               last_flag: (i == n - 1)});
    end
  endtask

  task automatic wait_drained();
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] value);
    in_valid <= 1'b0;
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    vertex_count_cfg = value;
    settings_used++;
  endtask

  task automatic send_request(input logic req, input logic [VTX_W-1:0] src,
                              input logic [VTX_W-1:0] dst, input logic eb,
                              input logic typed, input logic [ROW_W-1:0] typed_bits);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= req;
    src_vertex <= src;
    dst_vertex <= dst;
    edge_bit   <= eb;
    do @(posedge clk); while (in_stall);
    apply_to_matrix(req, src, dst, eb);
    requests_sent++;
    if (req == REQ_CLOSURE) closures_sent++;
    if (typed) begin
      expected_rows.push_back('{vertex: '0, bits: typed_bits, last_flag: 1'b1});
    end else begin
      foreach (closure_rows[i]) expected_rows.push_back(closure_rows[i]);
    end
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin : rx_side
    int n;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req <= 1'b0;
        out_stall     <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    row_t exp_row;
    if (!rst && out_valid && !out_stall) begin
      rows_checked++;
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected row: idx %0d bits %h last %0b", row_index, row_bits, last_row);
      end else begin
        exp_row = expected_rows.pop_front();
        if (row_index !== exp_row.vertex || row_bits !== exp_row.bits ||
            last_row !== exp_row.last_flag) begin
          mismatches++;
          if (mismatches <= 10)
            $display("row mismatch: exp idx %0d bits %h last %0b, got idx %0d bits %h last %0b",
                     exp_row.vertex, exp_row.bits, exp_row.last_flag,
                     row_index, row_bits, last_row);
        end
      end
    end
  end

  initial begin : stimulus
    int phase;
    int n;
    int pick;
    int phase_items;
    int random_items;
    logic [CNT_W-1:0] cnt;
    logic req;
    logic eb;
    logic [VTX_W-1:0] src;
    logic [VTX_W-1:0] dst;

    foreach (reach_rows[i]) reach_rows[i] = '0;
    vertex_count_cfg = VC_RESET;
    random_items = 0;

    plan = '{
      '{1'b0, 7'd0,   REQ_CLOSURE, 6'd0,  6'd0,  1'b0, 1'b0, 64'd0},
      '{1'b1, 7'd0,   REQ_EDGE,    6'd0,  6'd0,  1'b0, 1'b0, 64'd0},
      '{1'b0, 7'd0,   REQ_CLOSURE, 6'd63, 6'd63, 1'b1, 1'b1, 64'd0},
      '{1'b0, 7'd0,   REQ_EDGE,    6'd0,  6'd0,  1'b1, 1'b0, 64'd0},
      '{1'b0, 7'd0,   REQ_CLOSURE, 6'd0,  6'd0,  1'b0, 1'b1, 64'd1},
      '{1'b0, 7'd0,   REQ_EDGE,    6'd0,  6'd0,  1'b0, 1'b0, 64'd0},
      '{1'b0, 7'd0,   REQ_CLOSURE, 6'd63, 6'd0,  1'b1, 1'b1, 64'd0},
      '{1'b1, 7'd127, REQ_EDGE,    6'd0,  6'd0,  1'b0, 1'b0, 64'd0},
      '{1'b0, 7'd0,   REQ_EDGE,    6'd0,  6'd63, 1'b1, 1'b0, 64'd0},
      '{1'b0, 7'd0,   REQ_EDGE,    6'd63, 6'd0,  1'b1, 1'b0, 64'd0},
      '{1'b0, 7'd0,   REQ_EDGE,    6'd5,  6'd0,  1'b1, 1'b0, 64'd0},
      '{1'b0, 7'd0,   REQ_EDGE,    6'd63, 6'd63, 1'b1, 1'b0, 64'd0},
      '{1'b0, 7'd0,   REQ_EDGE,    6'd63, 6'd63, 1'b0, 1'b0, 64'd0},
      '{1'b0, 7'd0,   REQ_CLOSURE, 6'd0,  6'd63, 1'b0, 1'b0, 64'd0},
      '{1'b1, 7'd2,   REQ_EDGE,    6'd0,  6'd0,  1'b0, 1'b0, 64'd0},
      '{1'b0, 7'd0,   REQ_EDGE,    6'd1,  6'd0,  1'b1, 1'b0, 64'd0},
      '{1'b0, 7'd0,   REQ_EDGE,    6'd10, 6'd1,  1'b1, 1'b0, 64'd0},
      '{1'b0, 7'd0,   REQ_EDGE,    6'd0,  6'd40, 1'b1, 1'b0, 64'd0},
      '{1'b0, 7'd0,   REQ_CLOSURE, 6'd21, 6'd42, 1'b1, 1'b0, 64'd0},
      '{1'b1, 7'd65,  REQ_EDGE,    6'd0,  6'd0,  1'b0, 1'b0, 64'd0},
      '{1'b0, 7'd0,   REQ_EDGE,    6'd33, 6'd34, 1'b1, 1'b0, 64'd0},
      '{1'b0, 7'd0,   REQ_CLOSURE, 6'd42, 6'd21, 1'b0, 1'b0, 64'd0},
      '{1'b1, 7'd1,   REQ_EDGE,    6'd0,  6'd0,  1'b0, 1'b0, 64'd0}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[s]) begin
      if (plan[s].is_cfg)
        write_count(plan[s].cfg_val);
      else
        send_request(plan[s].req, plan[s].src, plan[s].dst, plan[s].eb,
                     plan[s].typed, plan[s].typed_bits);
    end
    send_request(REQ_CLOSURE, 6'd0, 6'd0, 1'b0, 1'b0, '0);

    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        cnt = 7'd64;
      end else if (pick < 9) begin
        cnt = ($urandom_range(0, 1) != 0) ? 7'd0 : 7'($urandom_range(65, 127));
      end else if (pick < 14) begin
        cnt = 7'd1;
      end else begin
        cnt = 7'($urandom_range(2, 12));
      end
      if (phase == 1) cnt = 7'd6;
      write_count(cnt);
      n = active_vertices(cnt);
      phase_items = $urandom_range(4, 14);
      if (phase == 1) long_hold_req <= 1'b1;
      for (int j = 0; j < phase_items; j++) begin
        req = ($urandom_range(0, 99) < 20 || j == phase_items - 1) ? REQ_CLOSURE : REQ_EDGE;
        if (phase == 1 && j < 3) req = REQ_CLOSURE;
        if ($urandom_range(0, 99) < 15) begin
          src = VTX_W'($urandom_range(0, MAX_V - 1));
          dst = VTX_W'($urandom_range(0, MAX_V - 1));
        end else begin
          src = VTX_W'($urandom_range(0, n - 1));
          dst = VTX_W'($urandom_range(0, n - 1));
        end
        eb = ($urandom_range(0, 99) < 70);
        send_request(req, src, dst, eb, 1'b0, '0);
        random_items++;
        if (phase == 3 && j == phase_items / 2) begin
          in_valid <= 1'b0;
          wait_drained();
        end
      end
      phase++;
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d requests (%0d closures) across %0d vertex-count settings",
             requests_sent, closures_sent, settings_used);
    $display("Checked %0d emitted rows, %0d mismatches", rows_checked, mismatches);
    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
